/* rtl/aim_pkg.sv */
// shared widths and constants for the aligned interval merger
package aim_pkg;
    localparam int unsigned BEGIN_W = 48;
    localparam int unsigned END_W   = 49;
    localparam int unsigned ENTRY_W = BEGIN_W + END_W;
    localparam logic [END_W-1:0] LIMIT_RESET = {1'b1, {BEGIN_W{1'b0}}};
endpackage

/* rtl/aim_if.sv */
// handshake channels of the aligned interval merger
interface aim_in_if;
    logic                         valid;
    logic                         ready;
    logic [aim_pkg::BEGIN_W-1:0]  begin_offset;
    logic [aim_pkg::END_W-1:0]    end_offset;
    logic                         last;
    modport source (output valid, begin_offset, end_offset, last, input ready);
    modport sink   (input valid, begin_offset, end_offset, last, output ready);
endinterface

interface aim_out_if;
    logic                       valid;
    logic                       ready;
    logic [aim_pkg::END_W-1:0]  range_begin;
    logic [aim_pkg::END_W-1:0]  range_end;
    logic                       final_range;
    logic                       empty_res;
    logic                       overflow;
    modport source (output valid, range_begin, range_end, final_range, empty_res, overflow,
                    input ready);
    modport sink   (input valid, range_begin, range_end, final_range, empty_res, overflow,
                    output ready);
endinterface

interface aim_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [aim_pkg::END_W-1:0]  data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/aligned_interval_merger_unit.sv */
// aligned interval merger: align, clamp, sorted insert into store, merge and emit
//  channel  dir  beat carries
//  i_in     in   begin_offset, end_offset, last
//  o_out    out  range_begin, range_end, final_range, empty_res, overflow
//  i_cfg    in   store_limit write data
// a range is accepted in S_IDLE, then inserted in sorted order: for each entry it moves
// past, S_SHIFT_RD reads the store and S_SHIFT_CMP compares and writes on the store port;
// the first range of a batch is written in place at once, and S_PUT writes slot zero.
// after the last beat, the merge scan reads the store once per entry (S_MERGE_RD, then
// S_MERGE_CMP) and S_FINAL loads the final beat; o_out stalls hold the scan in place.
// i_rst_n clears count, drop flag, limit and control; store contents are not cleared.
module aligned_interval_merger_unit #(
    parameter int unsigned MAX_RANGES  = 64,
    parameter int unsigned ALIGN_SHIFT = 21
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aim_in_if.sink        i_in,
    aim_out_if.source     o_out,
    aim_cfg_if.sink       i_cfg
);
    localparam int unsigned ADDR_W = $clog2(MAX_RANGES);
    localparam int unsigned CNT_W  = $clog2(MAX_RANGES + 1);
    localparam int unsigned BW     = aim_pkg::BEGIN_W;
    localparam int unsigned EW     = aim_pkg::END_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SHIFT_RD, S_SHIFT_CMP, S_PUT, S_MERGE_RD, S_MERGE_CMP, S_FINAL
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic                r_dropped;
    logic                r_last;
    logic [BW-1:0]       r_nb;
    logic [EW-1:0]       r_ne;
    logic [ADDR_W-1:0]   r_j;
    logic [CNT_W-1:0]    r_i;
    logic [EW-1:0]       r_cb;
    logic [EW-1:0]       r_ce;
    logic                r_empty;
    logic [EW-1:0]       r_limit;
    logic                r_ov;
    logic [EW-1:0]       r_ob;
    logic [EW-1:0]       r_oe;
    logic                r_ofin;
    logic                r_oemp;
    logic                r_oovf;

    logic [BW-1:0]       w_bmask;
    logic [EW:0]         w_emask;
    logic [BW-1:0]       w_ab;
    logic [EW:0]         w_ae_wide;
    logic [EW-1:0]       w_ae;
    logic                w_keep;
    logic                w_full;
    logic                w_acc;
    logic                w_slot;
    logic                w_emit;
    logic                w_wr_en;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [aim_pkg::ENTRY_W-1:0] w_wr_data;
    logic                w_rd_en;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic [aim_pkg::ENTRY_W-1:0] w_q;
    logic [BW-1:0]       w_qb;
    logic [EW-1:0]       w_qe;
    logic                w_less;
    logic [CNT_W-1:0]    w_i_nx;
    logic [CNT_W-1:0]    w_cnt_nx;

    assign w_bmask   = BW'((64'd1 << ALIGN_SHIFT) - 64'd1);
    assign w_emask   = (EW+1)'((64'd1 << ALIGN_SHIFT) - 64'd1);
    assign w_ab      = i_in.begin_offset & ~w_bmask;
    assign w_ae_wide = ({1'b0, i_in.end_offset} + w_emask) & ~w_emask;
    assign w_ae      = (w_ae_wide > {1'b0, r_limit}) ? r_limit : w_ae_wide[EW-1:0];
    assign w_keep    = w_ae > {1'b0, w_ab};
    assign w_full    = r_count == CNT_W'(MAX_RANGES);
    assign w_acc     = i_in.valid && i_in.ready;
    assign w_slot    = !r_ov || o_out.ready;
    assign w_cnt_nx  = (w_keep && !w_full) ? r_count + CNT_W'(1) : r_count;
    assign w_i_nx    = r_i + CNT_W'(1);

    // a result beat is loaded into the output register this cycle
    assign w_emit = w_slot && ((r_state == S_FINAL) ||
                    (r_state == S_MERGE_CMP && r_i != '0 && {1'b0, w_qb} > r_ce));

    assign i_in.ready  = r_state == S_IDLE;
    assign i_cfg.ready = 1'b1;

    assign w_qb   = w_q[aim_pkg::ENTRY_W-1 -: BW];
    assign w_qe   = w_q[EW-1:0];
    assign w_less = {r_nb, r_ne} < {w_qb, w_qe};

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_j;
        w_wr_data = {r_nb, r_ne};
        w_rd_en   = 1'b0;
        w_rd_addr = r_j - ADDR_W'(1);
        unique case (r_state)
            S_IDLE: begin
                // first range of a batch goes straight to slot zero
                w_wr_en   = w_acc && w_keep && (r_count == '0);
                w_wr_addr = '0;
                w_wr_data = {w_ab, w_ae};
            end
            S_SHIFT_RD: begin
                w_rd_en = 1'b1;
            end
            S_SHIFT_CMP: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_less ? w_q : {r_nb, r_ne};
            end
            S_PUT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = '0;
            end
            S_MERGE_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_i[ADDR_W-1:0];
            end
            S_MERGE_CMP, S_FINAL: begin
            end
            default: begin
            end
        endcase
    end

    aim_store #(
        .DEPTH (MAX_RANGES),
        .WIDTH (aim_pkg::ENTRY_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_limit   <= aim_pkg::LIMIT_RESET;
            r_ov      <= 1'b0;
            r_last    <= 1'b0;
            r_empty   <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_limit <= i_cfg.data;
            end
            if (o_out.ready && !w_emit) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_nb    <= w_ab;
                        r_ne    <= w_ae;
                        r_last  <= i_in.last;
                        r_j     <= r_count[ADDR_W-1:0];
                        r_i     <= '0;
                        r_count <= w_cnt_nx;
                        r_empty <= w_cnt_nx == '0;
                        r_cb    <= '0;
                        r_ce    <= '0;
                        if (w_keep && w_full) begin
                            r_dropped <= 1'b1;
                        end
                        priority if (w_keep && !w_full && r_count != '0) begin
                            r_state <= S_SHIFT_RD;
                        end else if (i_in.last && w_cnt_nx == '0) begin
                            r_state <= S_FINAL;
                        end else if (i_in.last) begin
                            r_state <= S_MERGE_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SHIFT_RD: begin
                    r_state <= S_SHIFT_CMP;
                end
                S_SHIFT_CMP: begin
                    if (w_less) begin
                        r_j     <= r_j - ADDR_W'(1);
                        r_state <= (r_j == ADDR_W'(1)) ? S_PUT : S_SHIFT_RD;
                    end else begin
                        r_state <= r_last ? S_MERGE_RD : S_IDLE;
                    end
                end
                S_PUT: begin
                    r_state <= r_last ? S_MERGE_RD : S_IDLE;
                end
                S_MERGE_RD: begin
                    r_state <= S_MERGE_CMP;
                end
                S_MERGE_CMP: begin
                    priority if (r_i == '0) begin
                        r_cb    <= {1'b0, w_qb};
                        r_ce    <= w_qe;
                        r_i     <= w_i_nx;
                        r_state <= (w_i_nx == r_count) ? S_FINAL : S_MERGE_RD;
                    end else if ({1'b0, w_qb} <= r_ce) begin
                        // overlapping or touching: extend the open range
                        if (w_qe > r_ce) begin
                            r_ce <= w_qe;
                        end
                        r_i     <= w_i_nx;
                        r_state <= (w_i_nx == r_count) ? S_FINAL : S_MERGE_RD;
                    end else if (w_slot) begin
                        r_ov    <= 1'b1;
                        r_ob    <= r_cb;
                        r_oe    <= r_ce;
                        r_ofin  <= 1'b0;
                        r_oemp  <= 1'b0;
                        r_oovf  <= r_dropped;
                        r_cb    <= {1'b0, w_qb};
                        r_ce    <= w_qe;
                        r_i     <= w_i_nx;
                        r_state <= (w_i_nx == r_count) ? S_FINAL : S_MERGE_RD;
                    end else begin
                        r_state <= S_MERGE_CMP;
                    end
                end
                S_FINAL: begin
                    if (w_slot) begin
                        r_ov      <= 1'b1;
                        r_ob      <= r_cb;
                        r_oe      <= r_ce;
                        r_ofin    <= 1'b1;
                        r_oemp    <= r_empty;
                        r_oovf    <= r_dropped;
                        r_count   <= '0;
                        r_dropped <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.range_begin = r_ob;
    assign o_out.range_end   = r_oe;
    assign o_out.final_range = r_ofin;
    assign o_out.empty_res   = r_oemp;
    assign o_out.overflow    = r_oovf;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RANGES))
        else $error("held range count above capacity");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && w_slot) |=> (r_count == '0 && !r_dropped))
        else $error("batch state not cleared after final beat");

    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oemp) |-> (r_ofin && r_ob == '0 && r_oe == '0))
        else $error("empty result beat is malformed");

    a_merged_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_oemp) |-> (r_oe > r_ob))
        else $error("result range is empty");
`endif
endmodule

/* rtl/aim_store.sv */
// single-port-write, registered-read store of held ranges
module aim_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 97
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;
endmodule

/* tb/sv/aim_tb_if.sv */
`timescale 1ns / 100ps
// channel interfaces are taken from the rtl; this file holds tb-side beat types
package aim_tb_pkg;
    typedef struct packed {
        logic [aim_pkg::BEGIN_W-1:0] begin_offset;
        logic [aim_pkg::END_W-1:0]   end_offset;
        logic                        last;
    } t_range_beat;

    typedef struct packed {
        logic [aim_pkg::END_W-1:0] range_begin;
        logic [aim_pkg::END_W-1:0] range_end;
        logic                      final_range;
        logic                      empty_res;
        logic                      overflow;
    } t_merged_beat;
endpackage

/* tb/sv/aligned_interval_merger_unit_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the aligned interval merger unit
module aligned_interval_merger_unit_tb;
    localparam int unsigned BW = aim_pkg::BEGIN_W;
    localparam int unsigned EW = aim_pkg::END_W;
    localparam int unsigned MAX_RANGES  = 64;
    localparam int unsigned ALIGN_SHIFT = 21;
    localparam logic [EW-1:0] PAGE_MASK = (EW'(1) << ALIGN_SHIFT) - EW'(1);
    localparam logic [EW-1:0] TOP = EW'(1) << BW;
    localparam int unsigned CYCLE_LIMIT = 1500000;
    localparam int unsigned N_DIRECTED = 14;

    logic i_clk;
    logic i_rst_n;
    aim_in_if  in_ch();
    aim_out_if out_ch();
    aim_cfg_if cfg_ch();

    aligned_interval_merger_unit #(
        .MAX_RANGES (MAX_RANGES),
        .ALIGN_SHIFT(ALIGN_SHIFT)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // predictor state
    logic [EW-1:0]   limit_q;
    logic [BW-1:0]   kept_begin[$];
    logic [EW-1:0]   kept_end[$];
    logic            dropped_q;
    aim_tb_pkg::t_merged_beat pending_ranges[$];

    int unsigned errors;
    int unsigned cycles;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [EW-1:0] got,
                                   input logic [EW-1:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // align, clamp, store; on last sort, merge and queue expected beats
    task automatic predict_merge(input aim_tb_pkg::t_range_beat b);
        logic [BW-1:0]   ab;
        logic [EW:0]     ae;
        logic [EW-1:0]   cb, ce;
        logic [BW-1:0]   sb[$];
        logic [EW-1:0]   se[$];
        aim_tb_pkg::t_merged_beat r;
        int              j;
        ab = b.begin_offset & ~PAGE_MASK[BW-1:0];
        ae = ({1'b0, b.end_offset} + {1'b0, PAGE_MASK}) & ~{1'b0, PAGE_MASK};
        if (ae > {1'b0, limit_q}) ae = {1'b0, limit_q};
        if (ae > {2'b0, ab}) begin
            if (kept_begin.size() < MAX_RANGES) begin
                kept_begin.insert(kept_begin.size(), ab);
                kept_end.insert(kept_end.size(), ae[EW-1:0]);
            end else begin
                dropped_q = 1'b1;
            end
        end
        if (!b.last) return;
        if (kept_begin.size() == 0) begin
            r = '{range_begin: '0, range_end: '0, final_range: 1'b1, empty_res: 1'b1,
                  overflow: dropped_q};
            pending_ranges.insert(pending_ranges.size(), r);
        end else begin
            for (int i = 0; i < kept_begin.size(); i++) begin
                j = 0;
                while (j < sb.size() && (sb[j] < kept_begin[i] ||
                       (sb[j] == kept_begin[i] && se[j] <= kept_end[i]))) j++;
                sb.insert(j, kept_begin[i]);
                se.insert(j, kept_end[i]);
            end
            cb = {1'b0, sb[0]};
            ce = se[0];
            for (int i = 1; i < sb.size(); i++) begin
                if ({1'b0, sb[i]} <= ce) begin
                    if (se[i] > ce) ce = se[i];
                end else begin
                    r = '{cb, ce, 1'b0, 1'b0, dropped_q};
                    pending_ranges.insert(pending_ranges.size(), r);
                    cb = {1'b0, sb[i]};
                    ce = se[i];
                end
            end
            r = '{cb, ce, 1'b1, 1'b0, dropped_q};
            pending_ranges.insert(pending_ranges.size(), r);
        end
        kept_begin.delete();
        kept_end.delete();
        dropped_q = 1'b0;
    endtask

    // receiver: random stall, compare each beat against the oldest expectation
    always @(posedge i_clk) begin
        aim_tb_pkg::t_merged_beat want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_ranges.size() == 0) begin
                    report_mismatch("unexpected beat", out_ch.range_begin, '0);
                end else begin
                    want = pending_ranges.pop_front();
                    if (out_ch.range_begin !== want.range_begin)
                        report_mismatch("range_begin", out_ch.range_begin, want.range_begin);
                    if (out_ch.range_end !== want.range_end)
                        report_mismatch("range_end", out_ch.range_end, want.range_end);
                    if (out_ch.final_range !== want.final_range)
                        report_mismatch("final_range", EW'(out_ch.final_range),
                                        EW'(want.final_range));
                    if (out_ch.empty_res !== want.empty_res)
                        report_mismatch("empty_res", EW'(out_ch.empty_res),
                                        EW'(want.empty_res));
                    if (out_ch.overflow !== want.overflow)
                        report_mismatch("overflow", EW'(out_ch.overflow),
                                        EW'(want.overflow));
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid stays high after the accepting edge; the next beat or an idle drops it
    task automatic send_range(input aim_tb_pkg::t_range_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.begin_offset <= b.begin_offset;
        in_ch.end_offset   <= b.end_offset;
        in_ch.last         <= b.last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_merge(b);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_ranges.size() != 0) @(posedge i_clk);
        // a non-last beat can still be inserting when the last result leaves
        repeat (2 * MAX_RANGES + 8) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [EW-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        limit_q = value;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [BW-1:0] rand_begin(input int unsigned mode);
        logic [BW-1:0] v;
        v = BW'({$urandom, $urandom});
        unique case (mode)
            0: return {20'b0, v[27:0]};
            1: return v;
            default: return {BW{1'b1}} - {24'b0, v[23:0]};
        endcase
    endfunction

    // random batch with random range lengths, mostly small; an occasional end is random junk
    task automatic send_batch(input int unsigned n_ranges, input int unsigned mode);
        aim_tb_pkg::t_range_beat b;
        logic [EW-1:0] len;
        for (int i = 0; i < n_ranges; i++) begin
            b.begin_offset = rand_begin(mode);
            len = ($urandom_range(9) == 0) ? EW'(0) : EW'($urandom_range(1, 1 << 24));
            b.end_offset = ($urandom_range(19) == 0) ? EW'({$urandom, $urandom})
                                                     : {1'b0, b.begin_offset} + len;
            b.last = (i == n_ranges - 1);
            send_range(b);
        end
    endtask

    aim_tb_pkg::t_range_beat  directed_rows[N_DIRECTED];
    aim_tb_pkg::t_merged_beat directed_want[N_DIRECTED];
    bit directed_known[N_DIRECTED];

    initial begin
        aim_tb_pkg::t_range_beat b;
        errors = 0;
        cycles = 0;
        send_idle_pct = 35;
        recv_idle_pct = 65;
        limit_q = aim_pkg::LIMIT_RESET;
        dropped_q = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.begin_offset = '0;
        in_ch.end_offset = '0;
        in_ch.last = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;

        // begin, end, last; expected beat given where it is obvious
        directed_rows = '{
            '{48'h0, 49'h0, 1'b1},                       // empty batch
            '{48'h0, 49'h1, 1'b1},                       // one byte -> one page
            '{{BW{1'b1}}, TOP, 1'b1},                    // top page
            '{48'h0, {EW{1'b1}}, 1'b1},                  // wide end, clamped
            '{48'h200000, 49'h200000, 1'b1},             // empty after alignment
            '{48'h400000, 49'h400001, 1'b0},
            '{48'h0, 49'h10, 1'b0},
            '{48'h100000, 49'h300000, 1'b1},             // unsorted, overlapping
            '{48'h0, 49'h200000, 1'b0},
            '{48'h200000, 49'h400000, 1'b1},             // touching merge
            '{48'h0, 49'h200000, 1'b0},
            '{48'h600000, 49'h800000, 1'b0},
            '{48'h0, 49'h100000, 1'b1},                  // duplicate begin
            '{48'hABCDEF123456, 49'hABCDEF923456, 1'b1}
        };
        directed_known = '{1, 1, 1, 1, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0};
        directed_want[0] = '{'0, '0, 1'b1, 1'b1, 1'b0};
        directed_want[1] = '{'0, 49'h200000, 1'b1, 1'b0, 1'b0};
        directed_want[2] = '{TOP - 49'h200000, TOP, 1'b1, 1'b0, 1'b0};
        directed_want[3] = '{'0, TOP, 1'b1, 1'b0, 1'b0};
        directed_want[4] = '{'0, '0, 1'b1, 1'b1, 1'b0};
        directed_want[9] = '{'0, 49'h400000, 1'b1, 1'b0, 1'b0};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (directed_known[i]) begin
                send_range(directed_rows[i]);
                if (pending_ranges.size() == 0) begin
                    report_mismatch($sformatf("table row %0d", i), '0,
                                    directed_want[i].range_end);
                end else if (pending_ranges[pending_ranges.size() - 1] !==
                             directed_want[i]) begin
                    report_mismatch($sformatf("table row %0d", i),
                                    pending_ranges[pending_ranges.size() - 1].range_end,
                                    directed_want[i].range_end);
                end
            end else begin
                send_range(directed_rows[i]);
            end
        end
        drain_results();

        // batch longer than the store: once a range is dropped, overflow flag on every beat
        send_batch(MAX_RANGES + 5, 1);
        drain_results();

        // limit extremes and middle values
        write_limit('0);
        send_batch(3, 0);
        drain_results();
        write_limit({EW{1'b1}});
        send_batch(4, 2);
        drain_results();
        write_limit(49'h4000000);
        send_batch(6, 0);
        drain_results();
        write_limit(49'h3FFFFFF);
        send_batch(5, 0);
        drain_results();
        write_limit(TOP);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 65 : 0;
            recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 35 : 0;
            for (int k = 0; k < 10; k++) begin
                int unsigned n;
                n = ($urandom_range(15) == 0) ? $urandom_range(50, MAX_RANGES + 3)
                                              : $urandom_range(1, 8);
                send_batch(n, $urandom_range(2));
                if (k == 5) begin
                    // broken input: a lone junk beat folded into the next batch
                    b = '{BW'({$urandom, $urandom}), EW'({$urandom, $urandom}), 1'b0};
                    send_range(b);
                end
            end
            drain_results();
            if (phase == 1) begin
                write_limit(EW'({$urandom, $urandom}) & 49'h0FFFFFFFFFFF);
                send_batch(8, 0);
                drain_results();
                write_limit(TOP);
            end
        end

        drain_results();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/aim_pkg.sv
rtl/aim_if.sv
rtl/aim_store.sv
rtl/aligned_interval_merger_unit.sv
tb/sv/aim_tb_if.sv
tb/sv/aligned_interval_merger_unit_tb.sv
